### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define ASSERT_OFF to drop
// every assertion from the build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every rising clock edge outside reset
`define LRMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// cond must never be true outside reset
`define LRMC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define LRMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRMC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hw/rtl/lrmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmc_pkg
// Shared types and constants of the line/rectangle midpoint classifier.
// ----------------------------------------------------------------------------
package lrmc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_STEPS_DEF  = 64;

    localparam int CFG_IDX_BITS = 3;

    typedef logic [3:0] t_code;

    localparam t_code CODE_NONE  = 4'd0;
    localparam t_code CODE_LEFT  = 4'd1;
    localparam t_code CODE_RIGHT = 4'd2;
    localparam t_code CODE_ABOVE = 4'd4;
    localparam t_code CODE_BELOW = 4'd8;

    typedef enum logic [1:0] {
        CLS_OUTSIDE = 2'd0,
        CLS_CROSS   = 2'd1,
        CLS_INSIDE  = 2'd2
    } t_line_class;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RECT_LEFT   = 3'd0,
        REG_RECT_TOP    = 3'd1,
        REG_RECT_RIGHT  = 3'd2,
        REG_RECT_BOTTOM = 3'd3
    } t_cfg_reg;

    // per-stage control: beat present, decision taken, decided class
    typedef struct packed {
        logic        valid;
        logic        done;
        t_line_class cls;
    } t_ctl;

    // region codes of start, end and midpoint
    typedef struct packed {
        t_code cs;
        t_code ce;
        t_code cm;
    } t_codes;

endpackage

### hw/rtl/line_rect_midpoint_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rect_midpoint_classify
// Classifies a line segment against the configured clip rectangle:
// 2 inside, 1 crossing, 0 outside, by fixed-point midpoint bisection.
// ----------------------------------------------------------------------------
// Takes one segment per cycle while input ready is high. The pipeline has
// two front stages for the end codes and the trivial cases, two register
// stages per bisection step (MAX_STEPS steps, 64 by default), and the output
// register. The bisection is fully unrolled, so the rate is set only by the
// output side: while a result waits, the pipeline keeps advancing until a
// second result lands in the one-beat skid entry; input ready then drops
// until the waiting result is taken. Rectangle registers are written through
// the config channel, which is always ready; write them only while no
// segment is in flight.
// ----------------------------------------------------------------------------
module line_rect_midpoint_classify
    import lrmc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [COORD_BITS-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_line_class
);

    localparam int W = COORD_BITS + FRAC_BITS;

    logic signed [COORD_BITS-1:0] r_rect_left;
    logic signed [COORD_BITS-1:0] r_rect_top;
    logic signed [COORD_BITS-1:0] r_rect_right;
    logic signed [COORD_BITS-1:0] r_rect_bottom;

    logic   en;
    t_ctl   last_ctl;

    t_ctl                w_ctl   [0:MAX_STEPS-1];
    t_codes              w_codes [0:MAX_STEPS-1];
    logic signed [W-1:0] w_sx    [0:MAX_STEPS-1];
    logic signed [W-1:0] w_sy    [0:MAX_STEPS-1];
    logic signed [W-1:0] w_ex    [0:MAX_STEPS-1];
    logic signed [W-1:0] w_ey    [0:MAX_STEPS-1];
    logic signed [W-1:0] w_mx    [0:MAX_STEPS-1];
    logic signed [W-1:0] w_my    [0:MAX_STEPS-1];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left   <= '0;
            r_rect_top    <= '0;
            r_rect_right  <= '0;
            r_rect_bottom <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RECT_LEFT: begin
                    r_rect_left <= i_cfg_data;
                end
                REG_RECT_TOP: begin
                    r_rect_top <= i_cfg_data;
                end
                REG_RECT_RIGHT: begin
                    r_rect_right <= i_cfg_data;
                end
                REG_RECT_BOTTOM: begin
                    r_rect_bottom <= i_cfg_data;
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    lrmc_entry #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_entry (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_rect_left  (r_rect_left),
        .i_rect_top   (r_rect_top),
        .i_rect_right (r_rect_right),
        .i_rect_bottom(r_rect_bottom),
        .o_ctl        (w_ctl[0]),
        .o_codes      (w_codes[0]),
        .o_sx         (w_sx[0]),
        .o_sy         (w_sy[0]),
        .o_ex         (w_ex[0]),
        .o_ey         (w_ey[0]),
        .o_mx         (w_mx[0]),
        .o_my         (w_my[0])
    );

    for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
        if (k < MAX_STEPS - 1) begin : g_mid
            lrmc_step #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_step (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (en),
                .i_rect_left  (r_rect_left),
                .i_rect_top   (r_rect_top),
                .i_rect_right (r_rect_right),
                .i_rect_bottom(r_rect_bottom),
                .i_ctl        (w_ctl[k]),
                .i_codes      (w_codes[k]),
                .i_sx         (w_sx[k]),
                .i_sy         (w_sy[k]),
                .i_ex         (w_ex[k]),
                .i_ey         (w_ey[k]),
                .i_mx         (w_mx[k]),
                .i_my         (w_my[k]),
                .o_ctl        (w_ctl[k+1]),
                .o_codes      (w_codes[k+1]),
                .o_sx         (w_sx[k+1]),
                .o_sy         (w_sy[k+1]),
                .o_ex         (w_ex[k+1]),
                .o_ey         (w_ey[k+1]),
                .o_mx         (w_mx[k+1]),
                .o_my         (w_my[k+1])
            );
        end else begin : g_last
            // only the decision leaves the last step
            lrmc_step #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_step (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (en),
                .i_rect_left  (r_rect_left),
                .i_rect_top   (r_rect_top),
                .i_rect_right (r_rect_right),
                .i_rect_bottom(r_rect_bottom),
                .i_ctl        (w_ctl[k]),
                .i_codes      (w_codes[k]),
                .i_sx         (w_sx[k]),
                .i_sy         (w_sy[k]),
                .i_ex         (w_ex[k]),
                .i_ey         (w_ey[k]),
                .i_mx         (w_mx[k]),
                .i_my         (w_my[k]),
                .o_ctl        (last_ctl),
                .o_codes      (),
                .o_sx         (),
                .o_sy         (),
                .o_ex         (),
                .o_ey         (),
                .o_mx         (),
                .o_my         ()
            );
        end
    end

    lrmc_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (last_ctl),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_line_class(o_line_class)
    );

endmodule

### hw/rtl/lrmc_region.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmc_region
// Region code of one fixed-point point against the clip rectangle.
// ----------------------------------------------------------------------------
module lrmc_region
    import lrmc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_x,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0]           i_rect_left,
    input  logic signed [COORD_BITS-1:0]           i_rect_top,
    input  logic signed [COORD_BITS-1:0]           i_rect_right,
    input  logic signed [COORD_BITS-1:0]           i_rect_bottom,
    output t_code                                  o_code
);

    localparam int W = COORD_BITS + FRAC_BITS;

    logic signed [W-1:0] lim_l;
    logic signed [W-1:0] lim_t;
    logic signed [W-1:0] lim_r;
    logic signed [W-1:0] lim_b;

    // edges in pixels scaled up to the fixed-point grid
    assign lim_l = {i_rect_left,   {FRAC_BITS{1'b0}}};
    assign lim_t = {i_rect_top,    {FRAC_BITS{1'b0}}};
    assign lim_r = {i_rect_right,  {FRAC_BITS{1'b0}}};
    assign lim_b = {i_rect_bottom, {FRAC_BITS{1'b0}}};

    always_comb begin
        o_code = CODE_NONE;
        if (i_x < lim_l) begin
            o_code = CODE_LEFT;
        end else if (i_x > lim_r) begin
            o_code = CODE_RIGHT;
        end
        if (i_y < lim_t) begin
            o_code = o_code | CODE_ABOVE;
        end else if (i_y > lim_b) begin
            o_code = o_code | CODE_BELOW;
        end
    end

endmodule

### hw/rtl/lrmc_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmc_entry
// Two front stages: end codes and first midpoint, then the trivial
// accept/reject decision and the first midpoint code.
// ----------------------------------------------------------------------------
module lrmc_entry
    import lrmc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [COORD_BITS-1:0]           i_start_x,
    input  logic signed [COORD_BITS-1:0]           i_start_y,
    input  logic signed [COORD_BITS-1:0]           i_end_x,
    input  logic signed [COORD_BITS-1:0]           i_end_y,
    input  logic signed [COORD_BITS-1:0]           i_rect_left,
    input  logic signed [COORD_BITS-1:0]           i_rect_top,
    input  logic signed [COORD_BITS-1:0]           i_rect_right,
    input  logic signed [COORD_BITS-1:0]           i_rect_bottom,
    output t_ctl                                   o_ctl,
    output t_codes                                 o_codes,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_sx,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_sy,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_ex,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_ey,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_mx,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_my
);

    localparam int W = COORD_BITS + FRAC_BITS;

    function automatic logic signed [W-1:0] half_floor(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return W'(s >>> 1);
    endfunction

    logic signed [W-1:0] sx;
    logic signed [W-1:0] sy;
    logic signed [W-1:0] ex;
    logic signed [W-1:0] ey;
    t_code               cs;
    t_code               ce;
    t_code               cm;

    logic                r1_valid;
    logic signed [W-1:0] r1_sx;
    logic signed [W-1:0] r1_sy;
    logic signed [W-1:0] r1_ex;
    logic signed [W-1:0] r1_ey;
    logic signed [W-1:0] r1_mx;
    logic signed [W-1:0] r1_my;
    t_code               r1_cs;
    t_code               r1_ce;

    t_ctl                n_ctl;
    t_ctl                r_ctl;
    t_codes              r_codes;
    logic signed [W-1:0] r_sx;
    logic signed [W-1:0] r_sy;
    logic signed [W-1:0] r_ex;
    logic signed [W-1:0] r_ey;
    logic signed [W-1:0] r_mx;
    logic signed [W-1:0] r_my;

    assign sx = {i_start_x, {FRAC_BITS{1'b0}}};
    assign sy = {i_start_y, {FRAC_BITS{1'b0}}};
    assign ex = {i_end_x,   {FRAC_BITS{1'b0}}};
    assign ey = {i_end_y,   {FRAC_BITS{1'b0}}};

    lrmc_region #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_reg_s (
        .i_x(sx), .i_y(sy),
        .i_rect_left(i_rect_left), .i_rect_top(i_rect_top),
        .i_rect_right(i_rect_right), .i_rect_bottom(i_rect_bottom),
        .o_code(cs)
    );

    lrmc_region #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_reg_e (
        .i_x(ex), .i_y(ey),
        .i_rect_left(i_rect_left), .i_rect_top(i_rect_top),
        .i_rect_right(i_rect_right), .i_rect_bottom(i_rect_bottom),
        .o_code(ce)
    );

    lrmc_region #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_reg_m (
        .i_x(r1_mx), .i_y(r1_my),
        .i_rect_left(i_rect_left), .i_rect_top(i_rect_top),
        .i_rect_right(i_rect_right), .i_rect_bottom(i_rect_bottom),
        .o_code(cm)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sx <= sx;
            r1_sy <= sy;
            r1_ex <= ex;
            r1_ey <= ey;
            r1_mx <= half_floor(sx, ex);
            r1_my <= half_floor(sy, ey);
            r1_cs <= cs;
            r1_ce <= ce;
        end
    end

    // stage 2: trivial cases
    always_comb begin
        n_ctl.valid = r1_valid;
        n_ctl.done  = 1'b1;
        n_ctl.cls   = CLS_OUTSIDE;
        if (r1_cs == CODE_NONE && r1_ce == CODE_NONE) begin
            n_ctl.cls = CLS_INSIDE;
        end else if (r1_cs == CODE_NONE || r1_ce == CODE_NONE) begin
            n_ctl.cls = CLS_CROSS;
        end else if ((r1_cs & r1_ce) == CODE_NONE) begin
            // no shared side: bisect
            n_ctl.done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
            r_ctl.done  <= 1'b0;
            r_ctl.cls   <= CLS_OUTSIDE;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_codes.cs <= r1_cs;
            r_codes.ce <= r1_ce;
            r_codes.cm <= cm;
            r_sx       <= r1_sx;
            r_sy       <= r1_sy;
            r_ex       <= r1_ex;
            r_ey       <= r1_ey;
            r_mx       <= r1_mx;
            r_my       <= r1_my;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_codes = r_codes;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;
    assign o_ex    = r_ex;
    assign o_ey    = r_ey;
    assign o_mx    = r_mx;
    assign o_my    = r_my;

endmodule

### hw/rtl/lrmc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmc_step
// One bisection step in two register stages: first the midpoint test and the
// start-side move, then the end side moves and the span test runs.
// ----------------------------------------------------------------------------
module lrmc_step
    import lrmc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic signed [COORD_BITS-1:0]           i_rect_left,
    input  logic signed [COORD_BITS-1:0]           i_rect_top,
    input  logic signed [COORD_BITS-1:0]           i_rect_right,
    input  logic signed [COORD_BITS-1:0]           i_rect_bottom,
    input  t_ctl                                   i_ctl,
    input  t_codes                                 i_codes,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_sx,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_sy,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_ex,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_ey,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_mx,
    input  logic signed [COORD_BITS+FRAC_BITS-1:0] i_my,
    output t_ctl                                   o_ctl,
    output t_codes                                 o_codes,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_sx,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_sy,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_ex,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_ey,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_mx,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_my
);

    localparam int W = COORD_BITS + FRAC_BITS;
    localparam logic signed [W:0] ONE_PX = (W+1)'(1) << FRAC_BITS;

    function automatic logic signed [W-1:0] half_floor(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return W'(s >>> 1);
    endfunction

    // start-side half
    logic                a_active;
    logic                a_move;
    logic signed [W-1:0] a_mx;
    logic signed [W-1:0] a_my;
    t_code               a_cm;
    t_ctl                n_a_ctl;
    t_codes              n_a_codes;
    logic signed [W-1:0] n_a_sx;
    logic signed [W-1:0] n_a_sy;
    logic signed [W-1:0] n_a_mx;
    logic signed [W-1:0] n_a_my;

    t_ctl                r_a_ctl;
    t_codes              r_a_codes;
    logic signed [W-1:0] r_a_sx;
    logic signed [W-1:0] r_a_sy;
    logic signed [W-1:0] r_a_ex;
    logic signed [W-1:0] r_a_ey;
    logic signed [W-1:0] r_a_mx;
    logic signed [W-1:0] r_a_my;

    // end-side half
    logic                b_active;
    logic                b_move;
    logic signed [W-1:0] b_mx;
    logic signed [W-1:0] b_my;
    t_code               b_cm;
    logic signed [W:0]   b_dx;
    logic signed [W:0]   b_dy;
    logic                b_small;
    t_ctl                n_b_ctl;
    t_codes              n_b_codes;
    logic signed [W-1:0] n_b_ex;
    logic signed [W-1:0] n_b_ey;
    logic signed [W-1:0] n_b_mx;
    logic signed [W-1:0] n_b_my;

    t_ctl                r_b_ctl;
    t_codes              r_b_codes;
    logic signed [W-1:0] r_b_sx;
    logic signed [W-1:0] r_b_sy;
    logic signed [W-1:0] r_b_ex;
    logic signed [W-1:0] r_b_ey;
    logic signed [W-1:0] r_b_mx;
    logic signed [W-1:0] r_b_my;

    assign a_mx = half_floor(i_mx, i_ex);
    assign a_my = half_floor(i_my, i_ey);

    lrmc_region #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_reg_a (
        .i_x(a_mx), .i_y(a_my),
        .i_rect_left(i_rect_left), .i_rect_top(i_rect_top),
        .i_rect_right(i_rect_right), .i_rect_bottom(i_rect_bottom),
        .o_code(a_cm)
    );

    always_comb begin
        a_active  = i_ctl.valid && !i_ctl.done;
        a_move    = (i_codes.cm & i_codes.cs) != CODE_NONE;
        n_a_ctl   = i_ctl;
        n_a_codes = i_codes;
        n_a_sx    = i_sx;
        n_a_sy    = i_sy;
        n_a_mx    = i_mx;
        n_a_my    = i_my;
        if (a_active) begin
            if (i_codes.cm == CODE_NONE) begin
                n_a_ctl.done = 1'b1;
                n_a_ctl.cls  = CLS_CROSS;
            end else if (a_move) begin
                // midpoint becomes the start
                n_a_sx       = i_mx;
                n_a_sy       = i_my;
                n_a_codes.cs = i_codes.cm;
                n_a_mx       = a_mx;
                n_a_my       = a_my;
                n_a_codes.cm = a_cm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
            r_a_ctl.done  <= 1'b0;
            r_a_ctl.cls   <= CLS_OUTSIDE;
        end else if (i_en) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_codes <= n_a_codes;
            r_a_sx    <= n_a_sx;
            r_a_sy    <= n_a_sy;
            r_a_ex    <= i_ex;
            r_a_ey    <= i_ey;
            r_a_mx    <= n_a_mx;
            r_a_my    <= n_a_my;
        end
    end

    assign b_mx = half_floor(r_a_sx, r_a_mx);
    assign b_my = half_floor(r_a_sy, r_a_my);

    lrmc_region #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_reg_b (
        .i_x(b_mx), .i_y(b_my),
        .i_rect_left(i_rect_left), .i_rect_top(i_rect_top),
        .i_rect_right(i_rect_right), .i_rect_bottom(i_rect_bottom),
        .o_code(b_cm)
    );

    always_comb begin
        b_active  = r_a_ctl.valid && !r_a_ctl.done;
        b_move    = (r_a_codes.cm & r_a_codes.ce) != CODE_NONE;
        n_b_ctl   = r_a_ctl;
        n_b_codes = r_a_codes;
        n_b_ex    = r_a_ex;
        n_b_ey    = r_a_ey;
        n_b_mx    = r_a_mx;
        n_b_my    = r_a_my;
        if (b_active && b_move) begin
            // midpoint becomes the end
            n_b_ex       = r_a_mx;
            n_b_ey       = r_a_my;
            n_b_codes.ce = r_a_codes.cm;
            n_b_mx       = b_mx;
            n_b_my       = b_my;
            n_b_codes.cm = b_cm;
        end
        b_dx    = {r_a_sx[W-1], r_a_sx} - {n_b_ex[W-1], n_b_ex};
        b_dy    = {r_a_sy[W-1], r_a_sy} - {n_b_ey[W-1], n_b_ey};
        b_small = (b_dx < ONE_PX) && (b_dx > -ONE_PX)
               && (b_dy < ONE_PX) && (b_dy > -ONE_PX);
        if (b_active && b_small) begin
            // both spans under one pixel: outside
            n_b_ctl.done = 1'b1;
            n_b_ctl.cls  = CLS_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl.valid <= 1'b0;
            r_b_ctl.done  <= 1'b0;
            r_b_ctl.cls   <= CLS_OUTSIDE;
        end else if (i_en) begin
            r_b_ctl <= n_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_codes <= n_b_codes;
            r_b_sx    <= r_a_sx;
            r_b_sy    <= r_a_sy;
            r_b_ex    <= n_b_ex;
            r_b_ey    <= n_b_ey;
            r_b_mx    <= n_b_mx;
            r_b_my    <= n_b_my;
        end
    end

    assign o_ctl   = r_b_ctl;
    assign o_codes = r_b_codes;
    assign o_sx    = r_b_sx;
    assign o_sy    = r_b_sy;
    assign o_ex    = r_b_ex;
    assign o_ey    = r_b_ey;
    assign o_mx    = r_b_mx;
    assign o_my    = r_b_my;

endmodule

### hw/rtl/lrmc_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrmc_outbuf
// Output register plus one skid entry. The pipeline advances while the
// skid entry is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrmc_outbuf
    import lrmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output logic        o_en,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_line_class
);

    logic        r_out_valid;
    t_line_class r_out_cls;
    logic        r_skid_valid;
    t_line_class r_skid_cls;
    logic        pop;
    logic        push;

    assign o_en = !r_skid_valid;
    assign pop  = r_out_valid && i_out_ready;
    assign push = o_en && i_ctl.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid entry into the output register
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_cls <= r_skid_cls;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_cls <= i_ctl.cls;
            end else begin
                r_out_cls <= i_ctl.cls;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_class = r_out_cls;

    `LRMC_ASSERT_NEVER(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid, "skid beat without output beat")
    `LRMC_ASSERT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_out_ready |=> !r_skid_valid && r_out_valid, "skid beat did not drain")
    `LRMC_ASSERT(a_out_holds, i_clk, i_rst_n, r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_cls), "stalled result lost")

endmodule
